### hdl/mse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multiple LIFO stack engine.
package mse_pkg;

   // Data and field widths.
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 3;
   localparam int TYPE_W   = 2;
   localparam int ID_W     = 3;
   localparam int CFG_W    = 4;
   localparam int CSR_W    = 32;
   localparam int PADDR_W  = 3;

   // Number of stacks that a stack number can address.
   localparam int ID_STACKS = 1 << ID_W;

   // Request codes.
   localparam logic [TYPE_W-1:0] REQ_PUSH = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_POP  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_LIST = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_NONE = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

   // Register map: word index taken from the upper address bit.
   localparam logic CSR_STACKS_IN_USE = 1'b0;
   localparam logic [CFG_W-1:0] STACKS_RESET = 4'd8;

endpackage

### hdl/mse_stack_ram.sv
`timescale 1ns / 1ps
// Single-port entry memory holding the words of every stack.
module mse_stack_ram
   import mse_pkg::*;
#(
   parameter int WORDS  = 512,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WORD_W-1:0] wr_data,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [WORDS];
   logic [WORD_W-1:0] rd_data_ff;

   // One access a cycle; read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/multi_stack_engine.sv
`timescale 1ns / 1ps
// Top level of the multiple LIFO stack engine: sequencer, fill counters and register port.
//
// A bank of independent LIFO stacks of signed 32-bit words. A transaction is taken when start
// is high and busy is low; for any code but 3, busy then stays high until the request has been
// worked through. A push, or any request that ends in an error status, gives a single result;
// a pop reads the entry memory and then gives its result; a listing of n entries streams one
// result a cycle with rsp_last on the top entry. Request code 3 is taken and gives no result.
// The sequencing is set by the single-port entry memory with its registered read data and by
// the shared address and count adders. Results are shown for one cycle on rsp_strobe and
// cannot be held off, so the receiver must take every strobe.
// Stack contents need no clearing after reset: only entries below a stack's fill count are read.
module multi_stack_engine
   import mse_pkg::*;
#(
   parameter int STACK_DEPTH = 64,
   parameter int STACK_COUNT = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // Request channel
   input  logic                       start,
   output logic                       busy,
   input  logic [TYPE_W-1:0]          req_type,
   input  logic [ID_W-1:0]            req_stack_id,
   input  logic signed [WORD_W-1:0]   req_push_value,
   // Result channel
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [WORD_W-1:0]   rsp_value,
   output logic                       rsp_last,
   // Register port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [PADDR_W-1:0]         paddr,
   input  logic [CSR_W-1:0]           pwdata,
   output logic [CSR_W-1:0]           prdata,
   output logic                       pready
);

   localparam int USED_STACKS = (STACK_COUNT < ID_STACKS) ? STACK_COUNT : ID_STACKS;
   localparam int SID_W       = (USED_STACKS > 1) ? $clog2(USED_STACKS) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int ENTRIES     = USED_STACKS * STACK_DEPTH;
   localparam int ADDR_W      = $clog2(ENTRIES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_POP_DATA,
      S_LIST
   } state_type;

   state_type                 state_ff, state_in;
   logic [TYPE_W-1:0]         type_ff, type_in;
   logic [ID_W-1:0]           sid_ff, sid_in;
   logic [WORD_W-1:0]         word_ff, word_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]          fill_ff [USED_STACKS];
   logic [CFG_W-1:0]          stacks_ff;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]         rsp_value_ff, rsp_value_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [SID_W-1:0]          sid_sel;
   logic                      id_ok;
   logic [CNT_W-1:0]          fill_cur;
   logic                      fill_we;
   logic [CNT_W-1:0]          step_delta;
   logic [CNT_W-1:0]          step_sum;
   logic [IDX_W-1:0]          offset;
   logic [ADDR_W-1:0]         base;
   logic [ADDR_W-1:0]         mem_addr;
   logic                      mem_we;
   logic                      mem_re;
   logic [WORD_W-1:0]         mem_rd_data;
   logic [IDX_W-1:0]          idx_next;
   logic                      list_end;
   logic                      cfg_write;

   // Request decoding against the enabled stack count.
   assign sid_sel  = sid_ff[SID_W-1:0];
   assign id_ok    = (CFG_W'(sid_ff) < stacks_ff) && (32'(sid_ff) < STACK_COUNT);
   assign fill_cur = fill_ff[sid_sel];

   // Shared count unit: one up or one down on the addressed stack's fill count.
   assign step_delta = (type_ff == REQ_POP) ? {CNT_W{1'b1}} : CNT_W'(1);
   assign step_sum   = fill_cur + step_delta;

   // Shared address unit: stack base plus entry offset.
   assign base     = ADDR_W'(32'(sid_sel) * STACK_DEPTH);
   assign mem_addr = base + ADDR_W'(offset);

   // Listing walk position.
   assign idx_next = idx_ff + IDX_W'(1);
   assign list_end = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);

   // Sequencer next-state and result logic.
   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      sid_in        = sid_ff;
      word_in       = word_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      fill_we       = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      offset        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               type_in = req_type;
               sid_in  = req_stack_id;
               word_in = req_push_value;
               if (req_type != REQ_NONE) begin
                  state_in = S_DECODE;
               end
            end
         end
         S_DECODE: begin
            rsp_strobe_in = 1'b1;
            rsp_value_in  = '0;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
            if (!id_ok) begin
               rsp_status_in = ST_INVALID;
            end else if (type_ff == REQ_PUSH) begin
               if (fill_cur >= CNT_W'(STACK_DEPTH)) begin
                  rsp_status_in = ST_OVERFLOW;
               end else begin
                  offset        = fill_cur[IDX_W-1:0];
                  mem_we        = 1'b1;
                  fill_we       = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_value_in  = word_ff;
               end
            end else if (type_ff == REQ_POP) begin
               if (fill_cur == '0) begin
                  rsp_status_in = ST_UNDERFLOW;
               end else begin
                  // Result follows once the read data is back.
                  offset        = step_sum[IDX_W-1:0];
                  mem_re        = 1'b1;
                  fill_we       = 1'b1;
                  rsp_strobe_in = 1'b0;
                  state_in      = S_POP_DATA;
               end
            end else begin
               if (fill_cur == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  offset        = '0;
                  mem_re        = 1'b1;
                  idx_in        = '0;
                  cnt_in        = fill_cur;
                  rsp_strobe_in = 1'b0;
                  state_in      = S_LIST;
               end
            end
         end
         S_POP_DATA: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_OK;
            rsp_value_in  = mem_rd_data;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         S_LIST: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_OK;
            rsp_value_in  = mem_rd_data;
            rsp_last_in   = list_end;
            if (list_end) begin
               state_in = S_IDLE;
            end else begin
               // Fetch the next entry while this one is shown.
               idx_in = idx_next;
               offset = idx_next;
               mem_re = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      type_ff       <= type_in;
      sid_ff        <= sid_in;
      word_ff       <= word_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Fill counters, cleared by reset so that every stack starts empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < USED_STACKS; i++) begin
            fill_ff[i] <= '0;
         end
      end else if (fill_we) begin
         fill_ff[sid_sel] <= step_sum;
      end
   end

   // Configuration register.
   assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1] == CSR_STACKS_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         stacks_ff <= STACKS_RESET;
      end else if (cfg_write) begin
         stacks_ff <= pwdata[CFG_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[PADDR_W-1] == CSR_STACKS_IN_USE) ? CSR_W'(stacks_ff) : '0;

   // Entry memory.
   mse_stack_ram #(
      .WORDS  (ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (word_ff),
      .rd_data (mem_rd_data)
   );

   // Port outputs.
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

   // A result only follows a cycle in which a transaction was being worked on.
   a_strobe_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff != S_IDLE))
      else $error("result strobe without a transaction in progress");

   // Error and empty results carry a zero word and close the transaction.
   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff != ST_OK)) |-> (rsp_value_ff == '0) && rsp_last_ff)
      else $error("error result with data or without last marker");

   // The addressed stack never holds more than its depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE && id_ok) |-> (fill_cur <= CNT_W'(STACK_DEPTH)))
      else $error("fill count beyond stack depth");

   // A listing walk stays below the count captured at its start.
   a_list_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST) |-> (CNT_W'(idx_ff) < cnt_ff))
      else $error("listing walked past the top entry");

   // The memory is never written and read in the same cycle, and is written only in the decode step.
   a_single_access: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !mem_re && (state_ff == S_DECODE))
      else $error("entry memory written outside the decode step");

endmodule
